// ===== design/assert_macros.svh =====
// assertion macros shared by the sprite pixel pipeline modules
// no dependencies; included by the files that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== design/scsp_pkg.sv =====
// shared constants, register codes and stage tag type of the sprite pixel pipeline
// no dependencies; imported by every module of the block
package scsp_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int SIZE_RESET     = 64;
  localparam int D_FRAC         = 8;
  localparam int T_FRAC         = 16;
  localparam int T_BITS         = T_FRAC + 1;

  localparam logic [T_BITS-1:0] T_ONE   = 17'd65536;
  localparam logic [T_BITS-1:0] T_HALF  = 17'd32768;
  localparam logic [T_BITS-1:0] T_THIRD = 17'd21627;
  localparam logic [7:0]        BYTE_FULL  = 8'd255;
  localparam logic [23:0]       ALPHA_GAIN = 24'd510;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_MODE   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic valid;
    logic in_circle;
  } stage_tag_t;

endpackage

// ===== design/soft_circle_sprite_pixel.sv =====
// top level of the soft circle sprite pixel generator
// depends on scsp_pkg, scsp_geom, scsp_sqrt, scsp_div and scsp_shade
//
// Usage:
//   in channel  (in_valid/in_ready, pos_x, pos_y): one pixel coordinate per transaction
//   out channel (out_valid/out_ready, blue/green/red_pixel): three packed pixels per
//   input transaction, in input order
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data): 0 width, 1 height,
//   2 argb_mode; cfg_ready is always high, other indexes are ignored; write only
//   while no transaction is in flight
// Throughput: one transaction per cycle, sustained, while out_ready stays high.
// Pipeline: the geometry stages, then the square root pipeline (one root bit per stage,
//   COORD_BITS + 8 stages), the divider (one quotient bit per stage, 17 stages)
//   and the shading and output registers, from input acceptance to out_valid.
// Stall: when out_ready is low the result holds; one more result goes to a skid slot,
//   then in_ready drops and the whole pipeline freezes with nothing lost.
// Reset: synchronous; clears all valid bits, sets width and height to 64 and ARGB
//   packing; in_ready is high from the first cycle after reset.
module soft_circle_sprite_pixel #(
  parameter int COORD_BITS = scsp_pkg::COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_BITS-1:0] pos_x,
  input  logic [COORD_BITS-1:0] pos_y,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [31:0]           blue_pixel,
  output logic [31:0]           green_pixel,
  output logic [31:0]           red_pixel,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [COORD_BITS:0]   cfg_data
);
  import scsp_pkg::*;

  localparam int C = COORD_BITS;

  logic [C:0] sprite_width;
  logic [C:0] sprite_height;
  logic       argb_mode;

  logic                adv;
  stage_tag_t          g_tag, s_tag, d_tag;
  logic [2*C-1:0]      g_sum;
  logic [C-1:0]        g_radius, s_radius;
  logic [C+D_FRAC-1:0] s_root;
  logic [T_BITS-1:0]   d_t;

  assign cfg_ready = 1'b1;
  assign in_ready  = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      sprite_width  <= (C+1)'(SIZE_RESET);
      sprite_height <= (C+1)'(SIZE_RESET);
      argb_mode     <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WIDTH:  sprite_width  <= cfg_data;
        REG_HEIGHT: sprite_height <= cfg_data;
        REG_MODE:   argb_mode     <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  scsp_geom #(.COORD_BITS(COORD_BITS)) u_geom (
    .clk           (clk),
    .rst           (rst),
    .adv           (adv),
    .in_valid      (in_valid),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .sprite_width  (sprite_width),
    .sprite_height (sprite_height),
    .out_tag       (g_tag),
    .out_sum       (g_sum),
    .out_radius    (g_radius)
  );

  scsp_sqrt #(.COORD_BITS(COORD_BITS)) u_sqrt (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .in_tag     (g_tag),
    .in_sum     (g_sum),
    .in_radius  (g_radius),
    .out_tag    (s_tag),
    .out_root   (s_root),
    .out_radius (s_radius)
  );

  scsp_div #(.COORD_BITS(COORD_BITS)) u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_tag    (s_tag),
    .in_root   (s_root),
    .in_radius (s_radius),
    .out_tag   (d_tag),
    .out_t     (d_t)
  );

  scsp_shade u_shade (
    .clk         (clk),
    .rst         (rst),
    .in_tag      (d_tag),
    .in_t        (d_t),
    .argb_mode   (argb_mode),
    .pipe_ready  (adv),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .blue_pixel  (blue_pixel),
    .green_pixel (green_pixel),
    .red_pixel   (red_pixel)
  );

endmodule

// ===== design/scsp_geom.sv =====
// geometry front end: offsets from centre, squares, radius test
// depends on scsp_pkg
module scsp_geom #(
  parameter int COORD_BITS = scsp_pkg::COORD_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       adv,
  input  logic                       in_valid,
  input  logic [COORD_BITS-1:0]      pos_x,
  input  logic [COORD_BITS-1:0]      pos_y,
  input  logic [COORD_BITS:0]        sprite_width,
  input  logic [COORD_BITS:0]        sprite_height,
  output scsp_pkg::stage_tag_t       out_tag,
  output logic [2*COORD_BITS-1:0]    out_sum,
  output logic [COORD_BITS-1:0]      out_radius
);
  import scsp_pkg::*;

  localparam int C = COORD_BITS;

  logic [C-1:0] cx, cy, r_comb, dx_comb, dy_comb;
  logic [2*C:0] s_comb;
  logic         inside_comb;

  logic         v1, v2;
  logic [C-1:0] dx1, dy1, r1;
  logic [2*C-1:0] dx2, dy2, rr2;
  logic [C-1:0] r2;

  assign cx      = sprite_width[C:1];
  assign cy      = sprite_height[C:1];
  assign r_comb  = (cx < cy) ? cx : cy;
  assign dx_comb = (pos_x >= cx) ? pos_x - cx : cx - pos_x;
  assign dy_comb = (pos_y >= cy) ? pos_y - cy : cy - pos_y;

  assign s_comb      = {1'b0, dx2} + {1'b0, dy2};
  assign inside_comb = (r2 != '0) && (s_comb < {1'b0, rr2});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      v2      <= 1'b0;
      out_tag <= '0;
    end else if (adv) begin
      v1      <= in_valid;
      v2      <= v1;
      out_tag <= '{valid: v2, in_circle: inside_comb};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx1        <= dx_comb;
      dy1        <= dy_comb;
      r1         <= r_comb;
      dx2        <= dx1 * dx1;
      dy2        <= dy1 * dy1;
      rr2        <= r1 * r1;
      r2         <= r1;
      out_sum    <= inside_comb ? s_comb[2*C-1:0] : '0;
      out_radius <= r2;
    end
  end

endmodule

// ===== design/scsp_sqrt.sv =====
// pipelined digit-by-digit square root, one root bit per stage
// depends on scsp_pkg and assert_macros.svh
`include "assert_macros.svh"

module scsp_sqrt #(
  parameter int COORD_BITS = scsp_pkg::COORD_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   adv,
  input  scsp_pkg::stage_tag_t                   in_tag,
  input  logic [2*COORD_BITS-1:0]                in_sum,
  input  logic [COORD_BITS-1:0]                  in_radius,
  output scsp_pkg::stage_tag_t                   out_tag,
  output logic [COORD_BITS+scsp_pkg::D_FRAC-1:0] out_root,
  output logic [COORD_BITS-1:0]                  out_radius
);
  import scsp_pkg::*;

  localparam int C    = COORD_BITS;
  localparam int QW   = C + D_FRAC;
  localparam int RW   = 2 * QW;
  localparam int REMW = QW + 2;

  stage_tag_t       tag      [QW];
  logic [REMW-1:0]  rem      [QW];
  logic [QW-1:0]    root     [QW];
  logic [RW-1:0]    rad      [QW];
  logic [C-1:0]     radius   [QW];

  stage_tag_t       tag_in   [QW];
  logic [REMW-1:0]  rem_in   [QW];
  logic [QW-1:0]    root_in  [QW];
  logic [RW-1:0]    rad_in   [QW];
  logic [C-1:0]     radius_in[QW];

  logic [REMW-1:0]  rem_next [QW];
  logic [QW-1:0]    root_next[QW];
  logic [RW-1:0]    rad_next [QW];

  for (genvar k = 0; k < QW; k++) begin : g_src
    if (k == 0) begin : g_first
      assign tag_in[k]    = in_tag;
      assign rem_in[k]    = '0;
      assign root_in[k]   = '0;
      assign rad_in[k]    = {in_sum, {(2*D_FRAC){1'b0}}};
      assign radius_in[k] = in_radius;
    end else begin : g_rest
      assign tag_in[k]    = tag[k-1];
      assign rem_in[k]    = rem[k-1];
      assign root_in[k]   = root[k-1];
      assign rad_in[k]    = rad[k-1];
      assign radius_in[k] = radius[k-1];
    end
  end

  always_comb begin
    logic [REMW-1:0] rem_sh;
    logic [REMW-1:0] trial;
    logic            ge;
    for (int k = 0; k < QW; k++) begin
      rem_sh       = {rem_in[k][REMW-3:0], rad_in[k][RW-1 -: 2]};
      trial        = {root_in[k], 2'b01};
      ge           = rem_sh >= trial;
      rem_next[k]  = ge ? rem_sh - trial : rem_sh;
      root_next[k] = {root_in[k][QW-2:0], ge};
      rad_next[k]  = {rad_in[k][RW-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < QW; k++) begin
        tag[k] <= '0;
      end
    end else if (adv) begin
      for (int k = 0; k < QW; k++) begin
        tag[k] <= tag_in[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < QW; k++) begin
        rem[k]    <= rem_next[k];
        root[k]   <= root_next[k];
        rad[k]    <= rad_next[k];
        radius[k] <= radius_in[k];
      end
    end
  end

  assign out_tag    = tag[QW-1];
  assign out_root   = root[QW-1];
  assign out_radius = radius[QW-1];

  `ASSERT_IMPLIES(a_root_below_radius, clk, rst, out_tag.valid && out_tag.in_circle,
    (out_root < {out_radius, {D_FRAC{1'b0}}}), "distance root not below radius")

endmodule

// ===== design/scsp_div.sv =====
// pipelined restoring divider for the intensity t, one quotient bit per stage
// depends on scsp_pkg and assert_macros.svh
`include "assert_macros.svh"

module scsp_div #(
  parameter int COORD_BITS = scsp_pkg::COORD_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   adv,
  input  scsp_pkg::stage_tag_t                   in_tag,
  input  logic [COORD_BITS+scsp_pkg::D_FRAC-1:0] in_root,
  input  logic [COORD_BITS-1:0]                  in_radius,
  output scsp_pkg::stage_tag_t                   out_tag,
  output logic [scsp_pkg::T_BITS-1:0]            out_t
);
  import scsp_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int NW = C + 2 * D_FRAC;
  localparam int QS = T_BITS;

  logic [NW-1:0] num;

  stage_tag_t     tag      [QS];
  logic [C-1:0]   rem      [QS];
  logic [QS-1:0]  quo      [QS];
  logic [QS-1:0]  low      [QS];
  logic [C-1:0]   dvs      [QS];

  stage_tag_t     tag_in   [QS];
  logic [C-1:0]   rem_in   [QS];
  logic [QS-1:0]  quo_in   [QS];
  logic [QS-1:0]  low_in   [QS];
  logic [C-1:0]   dvs_in   [QS];

  logic [C-1:0]   rem_next [QS];
  logic [QS-1:0]  quo_next [QS];
  logic [QS-1:0]  low_next [QS];

  // (radius in Q.8 minus distance) scaled to Q.16
  assign num = {({in_radius, {D_FRAC{1'b0}}} - in_root), {D_FRAC{1'b0}}};

  for (genvar k = 0; k < QS; k++) begin : g_src
    if (k == 0) begin : g_first
      assign tag_in[k] = in_tag;
      assign rem_in[k] = C'(num[NW-1:QS]);
      assign quo_in[k] = '0;
      assign low_in[k] = num[QS-1:0];
      assign dvs_in[k] = in_radius;
    end else begin : g_rest
      assign tag_in[k] = tag[k-1];
      assign rem_in[k] = rem[k-1];
      assign quo_in[k] = quo[k-1];
      assign low_in[k] = low[k-1];
      assign dvs_in[k] = dvs[k-1];
    end
  end

  always_comb begin
    logic [C:0] rem_sh;
    logic [C:0] rem_sub;
    logic       ge;
    for (int k = 0; k < QS; k++) begin
      rem_sh      = {rem_in[k], low_in[k][QS-1]};
      ge          = rem_sh >= {1'b0, dvs_in[k]};
      rem_sub     = rem_sh - {1'b0, dvs_in[k]};
      rem_next[k] = ge ? rem_sub[C-1:0] : rem_sh[C-1:0];
      quo_next[k] = {quo_in[k][QS-2:0], ge};
      low_next[k] = {low_in[k][QS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < QS; k++) begin
        tag[k] <= '0;
      end
    end else if (adv) begin
      for (int k = 0; k < QS; k++) begin
        tag[k] <= tag_in[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < QS; k++) begin
        rem[k] <= rem_next[k];
        quo[k] <= quo_next[k];
        low[k] <= low_next[k];
        dvs[k] <= dvs_in[k];
      end
    end
  end

  assign out_tag = tag[QS-1];
  assign out_t   = quo[QS-1];

  `ASSERT_IMPLIES(a_t_in_range, clk, rst, out_tag.valid && out_tag.in_circle,
    (out_t <= T_ONE), "intensity above one")

endmodule

// ===== design/scsp_shade.sv =====
// alpha and highlight shaping, pixel packing, output register with skid slot
// depends on scsp_pkg and assert_macros.svh
`include "assert_macros.svh"

module scsp_shade (
  input  logic                         clk,
  input  logic                         rst,
  input  scsp_pkg::stage_tag_t         in_tag,
  input  logic [scsp_pkg::T_BITS-1:0]  in_t,
  input  logic                         argb_mode,
  output logic                         pipe_ready,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [31:0]                  blue_pixel,
  output logic [31:0]                  green_pixel,
  output logic [31:0]                  red_pixel
);
  import scsp_pkg::*;

  logic [23:0]       a_prod;
  logic [7:0]        alpha_comb;
  logic [T_BITS-1:0] t_diff;
  logic [T_BITS:0]   v_dbl;
  logic [T_BITS-1:0] v_comb;

  stage_tag_t        tag_a;
  logic [7:0]        alpha_a;
  logic [T_BITS-1:0] v_a;

  logic [23:0]       h_prod;
  logic [7:0]        h;
  logic [31:0]       blue_comb, green_comb, red_comb;
  logic              push;

  logic              skid_valid;
  logic [31:0]       skid_blue, skid_green, skid_red;

  assign a_prod     = 24'(in_t[T_FRAC-2:0]) * ALPHA_GAIN;
  assign alpha_comb = (in_t >= T_HALF) ? BYTE_FULL : a_prod[23:16];
  assign t_diff     = in_t - T_THIRD;
  assign v_dbl      = {t_diff, 1'b0};

  always_comb begin
    if (in_t <= T_THIRD) begin
      v_comb = '0;
    end else if (v_dbl > {1'b0, T_ONE}) begin
      v_comb = T_ONE;
    end else begin
      v_comb = v_dbl[T_BITS-1:0];
    end
  end

  assign pipe_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_a <= '0;
    end else if (pipe_ready) begin
      tag_a <= in_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_ready) begin
      alpha_a <= alpha_comb;
      v_a     <= v_comb;
    end
  end

  assign h_prod = 24'(v_a) * 24'(BYTE_FULL);
  assign h      = h_prod[23:16];

  always_comb begin
    if (!tag_a.in_circle) begin
      blue_comb  = '0;
      green_comb = '0;
      red_comb   = '0;
    end else if (argb_mode) begin
      blue_comb  = {alpha_a, h, h, BYTE_FULL};
      green_comb = {alpha_a, h, BYTE_FULL, h};
      red_comb   = {alpha_a, BYTE_FULL, h, h};
    end else begin
      blue_comb  = {h, h, BYTE_FULL, alpha_a};
      green_comb = {h, BYTE_FULL, h, alpha_a};
      red_comb   = {BYTE_FULL, h, h, alpha_a};
    end
  end

  assign push = pipe_ready && tag_a.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_ready) begin
        skid_valid <= 1'b0;
      end
    end else if (!out_valid || out_ready) begin
      out_valid <= push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_ready) begin
        blue_pixel  <= skid_blue;
        green_pixel <= skid_green;
        red_pixel   <= skid_red;
      end
    end else if (!out_valid || out_ready) begin
      if (push) begin
        blue_pixel  <= blue_comb;
        green_pixel <= green_comb;
        red_pixel   <= red_comb;
      end
    end else if (push) begin
      skid_blue  <= blue_comb;
      skid_green <= green_comb;
      skid_red   <= red_comb;
    end
  end

  `ASSERT_IMPLIES(a_empty_output_takes_more, clk, rst, !out_valid, pipe_ready,
    "pipeline stalled with empty output")
  `ASSERT_NEXT(a_skid_keeps_output, clk, rst, skid_valid, out_valid,
    "skid transaction without output transaction")

endmodule

// ===== verif/soft_circle_sprite_pixel_test.sv =====
// testbench for soft_circle_sprite_pixel: directed and random pixel coordinates
// checked against an in-bench model of the soft circle shading; depends on scsp_pkg
`timescale 1ns / 1ps

module soft_circle_sprite_pixel_test;
  import scsp_pkg::*;

  localparam int COORD_W      = COORD_BITS_DEF;
  localparam int PIPE_LATENCY = COORD_W + 29;
  localparam int CYCLE_LIMIT  = 500000;
  localparam logic [COORD_W-1:0] COORD_MAX = '1;
  localparam logic [COORD_W:0]   SIZE_MAX  = '1;

  typedef struct packed {
    logic [31:0] blue;
    logic [31:0] green;
    logic [31:0] red;
  } sprite_pixels_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic [COORD_W-1:0]   pos_x;
  logic [COORD_W-1:0]   pos_y;
  logic                 out_valid;
  logic                 out_ready;
  logic [31:0]          blue_pixel;
  logic [31:0]          green_pixel;
  logic [31:0]          red_pixel;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [1:0]           cfg_index;
  logic [COORD_W:0]     cfg_data;

  // configuration as last written to the block
  logic [COORD_W:0]     sprite_w;
  logic [COORD_W:0]     sprite_h;
  logic                 argb_sel;

  sprite_pixels_t       pending_pixels[$];
  int                   mismatch_count;
  int                   cycle_count;
  int                   source_stall_pct;
  int                   sink_stall_pct;
  int                   sink_hold_cycles;

  soft_circle_sprite_pixel DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .blue_pixel  (blue_pixel),
    .green_pixel (green_pixel),
    .red_pixel   (red_pixel),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic sprite_pixels_t shade_circle_pixel(input logic [COORD_W-1:0] x,
                                                        input logic [COORD_W-1:0] y);
    longint unsigned cx, cy, rad, dx, dy, dist_sq, scaled, root, trial;
    longint unsigned intensity, alpha, boost, hilite;
    logic [7:0]      a8, h8;
    sprite_pixels_t  px;
    int              b;
    px = '0;
    cx = sprite_w >> 1;
    cy = sprite_h >> 1;
    rad = (cx < cy) ? cx : cy;
    dx = (x >= cx) ? x - cx : cx - x;
    dy = (y >= cy) ? y - cy : cy - y;
    dist_sq = dx * dx + dy * dy;
    if (rad == 0 || dist_sq >= rad * rad)
      return px;
    // distance in 8 fractional bits, floor square root bit by bit
    scaled = dist_sq << 16;
    root = 0;
    for (b = 21; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= scaled)
        root = trial;
    end
    intensity = (((rad << 8) - root) << 8) / rad;
    if (intensity > T_ONE)
      intensity = T_ONE;
    alpha = (intensity >= T_HALF) ? BYTE_FULL : ((intensity * ALPHA_GAIN) >> 16);
    if (alpha > BYTE_FULL)
      alpha = BYTE_FULL;
    if (intensity <= T_THIRD) begin
      boost = 0;
    end else begin
      boost = (intensity - T_THIRD) * 2;
      if (boost > T_ONE)
        boost = T_ONE;
    end
    hilite = (boost * BYTE_FULL) >> 16;
    a8 = alpha[7:0];
    h8 = hilite[7:0];
    if (argb_sel) begin
      px.blue  = {a8, h8, h8, BYTE_FULL};
      px.green = {a8, h8, BYTE_FULL, h8};
      px.red   = {a8, BYTE_FULL, h8, h8};
    end else begin
      px.blue  = {h8, h8, BYTE_FULL, a8};
      px.green = {h8, BYTE_FULL, h8, a8};
      px.red   = {BYTE_FULL, h8, h8, a8};
    end
    return px;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap(input int pct);
    if ($urandom_range(0, 99) >= pct)
      return 0;
    if ($urandom_range(0, 9) == 0)
      return $urandom_range(8, 60);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [COORD_W:0] pick_size();
    case ($urandom_range(0, 19))
      0: return '0;
      1: return (COORD_W+1)'(1);
      2: return (COORD_W+1)'(1 << COORD_W);
      3: return SIZE_MAX;
      4, 5: return (COORD_W+1)'($urandom_range(0, SIZE_MAX));
      default: return (COORD_W+1)'($urandom_range(2, 400));
    endcase
  endfunction

  // biased toward the circle so that most pixels land inside it
  function automatic logic [COORD_W-1:0] pick_coord(input int centre, input int rad);
    int v;
    if (rad > 0 && $urandom_range(0, 9) < 7)
      v = centre - rad + $urandom_range(0, 2 * rad);
    else
      v = $urandom_range(0, COORD_MAX);
    if (v < 0)
      v = 0;
    if (v > COORD_MAX)
      v = COORD_MAX;
    return COORD_W'(v);
  endfunction

  task automatic send_pixel(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    int gap;
    gap = pick_gap(source_stall_pct);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pos_x    <= x;
    pos_y    <= y;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_pixels.push_back(shade_circle_pixel(x, y));
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input cfg_reg_t idx, input logic [COORD_W:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_WIDTH:  sprite_w = value;
      REG_HEIGHT: sprite_h = value;
      REG_MODE:   argb_sel = value[0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [COORD_W:0] w, input logic [COORD_W:0] h,
                            input logic mode);
    wait_for_results();
    write_register(REG_WIDTH, w);
    write_register(REG_HEIGHT, h);
    write_register(REG_MODE, {{COORD_W{1'b0}}, mode});
    cfg_valid <= 1'b0;
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%s mismatch: expected %08h, got %08h", name, want, got);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    sprite_pixels_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected transaction: %08h %08h %08h",
                   blue_pixel, green_pixel, red_pixel);
      end else begin
        want = pending_pixels.pop_front();
        compare_field("blue_pixel", want.blue, blue_pixel);
        compare_field("green_pixel", want.green, green_pixel);
        compare_field("red_pixel", want.red, red_pixel);
      end
    end
  end

  // result receiver with random stalls and requested long hold-offs
  initial begin : result_sink
    int stall;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (sink_hold_cycles > 0) begin
        stall = sink_hold_cycles;
        sink_hold_cycles = 0;
      end else begin
        stall = pick_gap(sink_stall_pct);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

  task automatic test_reset_defaults();
    source_stall_pct = 20;
    sink_stall_pct   = 20;
    send_pixel(32, 32);
    send_pixel(0, 0);
    send_pixel(COORD_MAX, COORD_MAX);
    send_pixel(0, 32);
    send_pixel(1, 32);
    send_pixel(32, 63);
    send_pixel(37, 32);
    send_pixel(42, 32);
    send_pixel(48, 32);
    send_pixel(49, 32);
    send_pixel(53, 32);
    send_pixel(54, 32);
  endtask

  task automatic test_rgba_packing();
    set_config(64, 64, 1'b0);
    send_pixel(32, 32);
    send_pixel(40, 36);
    send_pixel(49, 32);
  endtask

  task automatic test_zero_radius();
    set_config(1, 64, 1'b1);
    send_pixel(0, 0);
    send_pixel(0, 32);
    set_config(64, 0, 1'b0);
    send_pixel(32, 0);
    send_pixel(COORD_MAX, COORD_MAX);
  endtask

  task automatic test_extreme_sizes();
    set_config(SIZE_MAX, SIZE_MAX, 1'b1);
    send_pixel(COORD_MAX, COORD_MAX);
    send_pixel(0, COORD_MAX);
    send_pixel(1, COORD_MAX);
    send_pixel(2048, 2048);
    set_config((COORD_W+1)'(1 << COORD_W), (COORD_W+1)'(1 << COORD_W), 1'b0);
    send_pixel(2048, 2048);
    send_pixel(0, 2048);
    send_pixel(COORD_MAX, COORD_MAX);
  endtask

  task automatic test_random_traffic();
    int phase, n, cx, cy, rad;
    for (phase = 0; phase < 12; phase++) begin
      set_config(pick_size(), pick_size(), 1'($urandom_range(0, 1)));
      source_stall_pct = (phase % 3 == 0) ? 0 : $urandom_range(5, 50);
      sink_stall_pct   = (phase % 4 == 1) ? 0 : $urandom_range(5, 50);
      cx = sprite_w >> 1;
      cy = sprite_h >> 1;
      rad = (cx < cy) ? cx : cy;
      for (n = 0; n < 40; n++) begin
        if (phase % 4 == 2 && n == 20)
          wait_for_results();
        send_pixel(pick_coord(cx, rad), pick_coord(cy, rad));
      end
    end
  endtask

  task automatic test_output_backpressure();
    int n;
    set_config(128, 96, 1'b1);
    source_stall_pct = 0;
    sink_stall_pct   = 0;
    sink_hold_cycles = 300;
    for (n = 0; n < 120; n++)
      send_pixel(pick_coord(64, 48), pick_coord(48, 48));
    wait_for_results();
  endtask

  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    pos_x     <= '0;
    pos_y     <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_WIDTH;
    cfg_data  <= '0;
    sprite_w = (COORD_W+1)'(SIZE_RESET);
    sprite_h = (COORD_W+1)'(SIZE_RESET);
    argb_sel = 1'b1;
    mismatch_count   = 0;
    source_stall_pct = 0;
    sink_stall_pct   = 0;
    sink_hold_cycles = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_rgba_packing();
    test_zero_radius();
    test_extreme_sizes();
    test_random_traffic();
    test_output_backpressure();

    wait_for_results();
    repeat (PIPE_LATENCY + 20) @(posedge clk);
    if (mismatch_count == 0 && pending_pixels.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
